### rtl/bpf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bpf_pkg;

   localparam int COORD_W  = 20;
   localparam int MARGIN_W = 19;
   localparam int RADIAL_W = 20;
   localparam int RADIUS_W = 19;
   localparam int COUNT_W  = 4;
   localparam int SLOT_W   = 3;
   localparam int DIFF_W   = COORD_W + 1;
   // radius plus radial margin stays below 2**21
   localparam int REACH_W  = RADIAL_W + 1;
   localparam int SQ_W     = 2 * DIFF_W;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;

   localparam logic [SLOT_W-1:0] CORNER_LOW  = 3'd0;
   localparam logic [SLOT_W-1:0] CORNER_HIGH = 3'd1;

   typedef enum logic [1:0] {
      REQ_CLASSIFY = 2'd0,
      REQ_CORNER   = 2'd1,
      REQ_PILLAR   = 2'd2
   } req_kind_type;

   typedef enum logic [2:0] {
      CSR_MARGIN_X      = 3'd0,
      CSR_MARGIN_Y      = 3'd1,
      CSR_MARGIN_Z      = 3'd2,
      CSR_RADIAL_MARGIN = 3'd3,
      CSR_PILLAR_MIN_X  = 3'd4,
      CSR_PILLAR_Z_LOW  = 3'd5,
      CSR_PILLAR_Z_HIGH = 3'd6,
      CSR_PILLARS_USED  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic load_s1;
      logic load_s2;
      logic load_s3;
   } lane_ctrl_type;

endpackage

`default_nettype wire

### rtl/bpf_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module bpf_lane (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire bpf_pkg::lane_ctrl_type                  ctrl,
   input  wire logic                                    wr_en,
   input  wire logic signed [bpf_pkg::COORD_W-1:0]      wr_x,
   input  wire logic signed [bpf_pkg::COORD_W-1:0]      wr_y,
   input  wire logic        [bpf_pkg::RADIUS_W-1:0]     wr_radius,
   input  wire logic signed [bpf_pkg::COORD_W-1:0]      pt_x,
   input  wire logic signed [bpf_pkg::COORD_W-1:0]      pt_y,
   input  wire logic        [bpf_pkg::RADIAL_W-1:0]     radial_margin,
   output logic                                         near
);

   localparam int SUM_W = bpf_pkg::SQ_W + 1;

   logic signed [bpf_pkg::COORD_W-1:0]  cx_ff, cy_ff;
   logic        [bpf_pkg::RADIUS_W-1:0] rad_ff;

   logic signed [bpf_pkg::DIFF_W-1:0]   dx_in, dx_ff, dy_in, dy_ff;
   logic        [bpf_pkg::REACH_W-1:0]  reach_in, reach_ff;
   logic signed [bpf_pkg::SQ_W-1:0]     dx_wide, dy_wide;
   logic        [bpf_pkg::SQ_W-1:0]     dxsq_in, dxsq_ff, dysq_in, dysq_ff;
   logic        [bpf_pkg::SQ_W-1:0]     reachsq_in, reachsq_ff;
   logic                                near_in, near_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff  <= '0;
         cy_ff  <= '0;
         rad_ff <= '0;
      end else if (wr_en) begin
         cx_ff  <= wr_x;
         cy_ff  <= wr_y;
         rad_ff <= wr_radius;
      end
   end

   // stage 1: offsets from the centre and the reach
   always_comb begin
      dx_in    = bpf_pkg::DIFF_W'(pt_x) - bpf_pkg::DIFF_W'(cx_ff);
      dy_in    = bpf_pkg::DIFF_W'(pt_y) - bpf_pkg::DIFF_W'(cy_ff);
      reach_in = bpf_pkg::REACH_W'(rad_ff) + bpf_pkg::REACH_W'(radial_margin);
   end

   // stage 2: squares
   always_comb begin
      dx_wide    = bpf_pkg::SQ_W'(dx_ff);
      dy_wide    = bpf_pkg::SQ_W'(dy_ff);
      dxsq_in    = $unsigned(dx_wide * dx_wide);
      dysq_in    = $unsigned(dy_wide * dy_wide);
      reachsq_in = bpf_pkg::SQ_W'(reach_ff) * bpf_pkg::SQ_W'(reach_ff);
   end

   // stage 3: distance compare
   assign near_in = (SUM_W'(dxsq_ff) + SUM_W'(dysq_ff)) <= SUM_W'(reachsq_ff);

   always_ff @(posedge clock) begin
      if (ctrl.load_s1) begin
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
         reach_ff <= reach_in;
      end
      if (ctrl.load_s2) begin
         dxsq_ff    <= dxsq_in;
         dysq_ff    <= dysq_in;
         reachsq_ff <= reachsq_in;
      end
      if (ctrl.load_s3) begin
         near_ff <= near_in;
      end
   end

   assign near = near_ff;

endmodule

`default_nettype wire

### rtl/box_and_pillar_point_filter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// A classify word passes stage registers s1, s2, s3 and the output register to rsp_.
// One word per cycle unless stalled; per-pillar multiplier lanes are fully pipelined.
// Load words (corner, pillar) take effect for the next accepted word and give no result.
// Reset clears CSRs, cuboid corners, pillar table and all stage valid bits.

module box_and_pillar_point_filter_core #(
   parameter int PILLARS = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [1:0]                           req_type,
   input  wire logic [bpf_pkg::SLOT_W-1:0]           req_slot,
   input  wire logic signed [bpf_pkg::COORD_W-1:0]   req_x_value,
   input  wire logic signed [bpf_pkg::COORD_W-1:0]   req_y_value,
   input  wire logic signed [bpf_pkg::COORD_W-1:0]   req_z_value,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_remove_point,
   output logic                                      rsp_in_cuboid,
   output logic                                      rsp_in_pillar,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [bpf_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  wire logic [bpf_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [bpf_pkg::CSR_DATA_W-1:0]            csr_prdata,
   output logic                                      csr_pready
);

   localparam int CW = bpf_pkg::COORD_W;

   function automatic logic bpf_within(
      input logic signed [CW-1:0] v, lo, hi,
      input logic [bpf_pkg::MARGIN_W-1:0] m
   );
      logic signed [CW+1:0] v_w, lo_w, hi_w, m_w;
      v_w  = (CW+2)'(v);
      m_w  = (CW+2)'($signed({1'b0, m}));
      lo_w = (CW+2)'(lo) - m_w;
      hi_w = (CW+2)'(hi) + m_w;
      return (v_w >= lo_w) && (v_w <= hi_w);
   endfunction

   // configuration registers
   logic        [bpf_pkg::MARGIN_W-1:0] margin_x_ff, margin_y_ff, margin_z_ff;
   logic        [bpf_pkg::RADIAL_W-1:0] radial_margin_ff;
   logic signed [CW-1:0]                pillar_min_x_ff, pillar_z_low_ff, pillar_z_high_ff;
   logic        [bpf_pkg::COUNT_W-1:0]  pillars_used_ff;

   bpf_pkg::csr_index_type csr_index;
   logic                   csr_write;

   assign csr_index  = bpf_pkg::csr_index_type'(csr_paddr[bpf_pkg::CSR_ADDR_W-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_x_ff      <= '0;
         margin_y_ff      <= '0;
         margin_z_ff      <= '0;
         radial_margin_ff <= '0;
         pillar_min_x_ff  <= '0;
         pillar_z_low_ff  <= '0;
         pillar_z_high_ff <= '0;
         pillars_used_ff  <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            bpf_pkg::CSR_MARGIN_X:      margin_x_ff      <= csr_pwdata[bpf_pkg::MARGIN_W-1:0];
            bpf_pkg::CSR_MARGIN_Y:      margin_y_ff      <= csr_pwdata[bpf_pkg::MARGIN_W-1:0];
            bpf_pkg::CSR_MARGIN_Z:      margin_z_ff      <= csr_pwdata[bpf_pkg::MARGIN_W-1:0];
            bpf_pkg::CSR_RADIAL_MARGIN: radial_margin_ff <= csr_pwdata[bpf_pkg::RADIAL_W-1:0];
            bpf_pkg::CSR_PILLAR_MIN_X:  pillar_min_x_ff  <= $signed(csr_pwdata[CW-1:0]);
            bpf_pkg::CSR_PILLAR_Z_LOW:  pillar_z_low_ff  <= $signed(csr_pwdata[CW-1:0]);
            bpf_pkg::CSR_PILLAR_Z_HIGH: pillar_z_high_ff <= $signed(csr_pwdata[CW-1:0]);
            bpf_pkg::CSR_PILLARS_USED:  pillars_used_ff  <= csr_pwdata[bpf_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         bpf_pkg::CSR_MARGIN_X:      csr_prdata = bpf_pkg::CSR_DATA_W'(margin_x_ff);
         bpf_pkg::CSR_MARGIN_Y:      csr_prdata = bpf_pkg::CSR_DATA_W'(margin_y_ff);
         bpf_pkg::CSR_MARGIN_Z:      csr_prdata = bpf_pkg::CSR_DATA_W'(margin_z_ff);
         bpf_pkg::CSR_RADIAL_MARGIN: csr_prdata = bpf_pkg::CSR_DATA_W'(radial_margin_ff);
         bpf_pkg::CSR_PILLAR_MIN_X:  csr_prdata = bpf_pkg::CSR_DATA_W'(pillar_min_x_ff);
         bpf_pkg::CSR_PILLAR_Z_LOW:  csr_prdata = bpf_pkg::CSR_DATA_W'(pillar_z_low_ff);
         bpf_pkg::CSR_PILLAR_Z_HIGH: csr_prdata = bpf_pkg::CSR_DATA_W'(pillar_z_high_ff);
         bpf_pkg::CSR_PILLARS_USED:  csr_prdata = bpf_pkg::CSR_DATA_W'(pillars_used_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // pipeline handshake
   logic rdy1, rdy2, rdy3, rdy4;
   logic accept;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic s1_valid_in;

   assign rdy4      = !rsp_valid_ff || rsp_ready;
   assign rdy3      = !s3_valid_ff || rdy4;
   assign rdy2      = !s2_valid_ff || rdy3;
   assign rdy1      = !s1_valid_ff || rdy2;
   assign req_ready = rdy1;
   assign accept    = req_valid && rdy1;
   assign s1_valid_in = accept && (req_type == bpf_pkg::REQ_CLASSIFY);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rdy1) s1_valid_ff  <= s1_valid_in;
         if (rdy2) s2_valid_ff  <= s1_valid_ff;
         if (rdy3) s3_valid_ff  <= s2_valid_ff;
         if (rdy4) rsp_valid_ff <= s3_valid_ff;
      end
   end

   // cuboid corners
   logic signed [CW-1:0] lo_x_ff, lo_y_ff, lo_z_ff, hi_x_ff, hi_y_ff, hi_z_ff;
   logic                 corner_wr;

   assign corner_wr = accept && (req_type == bpf_pkg::REQ_CORNER);

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_x_ff <= '0;
         lo_y_ff <= '0;
         lo_z_ff <= '0;
         hi_x_ff <= '0;
         hi_y_ff <= '0;
         hi_z_ff <= '0;
      end else if (corner_wr) begin
         if (req_slot == bpf_pkg::CORNER_LOW) begin
            lo_x_ff <= req_x_value;
            lo_y_ff <= req_y_value;
            lo_z_ff <= req_z_value;
         end
         if (req_slot == bpf_pkg::CORNER_HIGH) begin
            hi_x_ff <= req_x_value;
            hi_y_ff <= req_y_value;
            hi_z_ff <= req_z_value;
         end
      end
   end

   // stage 1 box and zone tests, carried down with the word
   logic cub_in, zone_in;
   logic s1_cub_ff, s2_cub_ff, s3_cub_ff;
   logic s1_zone_ff, s2_zone_ff, s3_zone_ff;

   always_comb begin
      cub_in  = bpf_within(req_x_value, lo_x_ff, hi_x_ff, margin_x_ff)
             && bpf_within(req_y_value, lo_y_ff, hi_y_ff, margin_y_ff)
             && bpf_within(req_z_value, lo_z_ff, hi_z_ff, margin_z_ff);
      zone_in = (req_x_value >= pillar_min_x_ff)
             && bpf_within(req_z_value, pillar_z_low_ff, pillar_z_high_ff, margin_z_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_cub_ff  <= cub_in;
         s1_zone_ff <= zone_in;
      end
      if (rdy2) begin
         s2_cub_ff  <= s1_cub_ff;
         s2_zone_ff <= s1_zone_ff;
      end
      if (rdy3) begin
         s3_cub_ff  <= s2_cub_ff;
         s3_zone_ff <= s2_zone_ff;
      end
   end

   // pillar lanes
   bpf_pkg::lane_ctrl_type     lane_ctrl;
   logic [PILLARS-1:0]         lane_near, lane_on, lane_wr;
   logic [bpf_pkg::RADIUS_W-1:0] wr_radius;

   assign lane_ctrl.load_s1 = rdy1;
   assign lane_ctrl.load_s2 = rdy2;
   assign lane_ctrl.load_s3 = rdy3;

   // clamp a negative radius to zero
   assign wr_radius = req_z_value[CW-1] ? '0 : req_z_value[bpf_pkg::RADIUS_W-1:0];

   for (genvar gi = 0; gi < PILLARS; gi++) begin : g_lane
      assign lane_wr[gi] = accept && (req_type == bpf_pkg::REQ_PILLAR)
                        && (32'(req_slot) == gi);
      assign lane_on[gi] = 32'(pillars_used_ff) > gi;

      bpf_lane u_lane (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (lane_ctrl),
         .wr_en         (lane_wr[gi]),
         .wr_x          (req_x_value),
         .wr_y          (req_y_value),
         .wr_radius     (wr_radius),
         .pt_x          (req_x_value),
         .pt_y          (req_y_value),
         .radial_margin (radial_margin_ff),
         .near          (lane_near[gi])
      );
   end

   // stage 4: output register
   logic pil_in;
   logic rsp_cub_ff, rsp_pil_ff;

   assign pil_in = s3_zone_ff && |(lane_near & lane_on);

   always_ff @(posedge clock) begin
      if (rdy4) begin
         rsp_cub_ff <= s3_cub_ff;
         rsp_pil_ff <= pil_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_in_cuboid    = rsp_cub_ff;
   assign rsp_in_pillar    = rsp_pil_ff;
   assign rsp_remove_point = rsp_cub_ff || rsp_pil_ff;

   // load words never enter the result pipeline
   a_load_no_word: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_type != bpf_pkg::REQ_CLASSIFY)) |=> !s1_valid_ff)
      else $error("load word entered result pipeline");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !rdy3) |=> s2_valid_ff)
      else $error("stage 2 word dropped during stall");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s3_valid_ff))
      else $error("result appeared without a stage 3 word");

endmodule

`default_nettype wire
